/* design/static_nat_rewrite_with_checksum_assert.svh */
// assertion macros for the nat rewrite block
`ifndef STATIC_NAT_REWRITE_WITH_CHECKSUM_ASSERT_SVH
`define STATIC_NAT_REWRITE_WITH_CHECKSUM_ASSERT_SVH

// consequent holds in the same cycle
`define SNRC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the next cycle
`define SNRC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/snrc_pkg.sv */
`default_nettype none
package snrc_pkg;

   localparam int MAX_RULES = 64;
   localparam int IDX_W     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
   localparam int COUNT_W   = 7;
   localparam int RIDX_W    = 6;
   localparam int CMP_W     = ((IDX_W > COUNT_W) ? IDX_W : COUNT_W) + 1;
   localparam int ACC_W     = 20;
   localparam int SUM_W     = 21;

   localparam logic       REQ_LOAD  = 1'b0;
   localparam logic       REQ_PKT   = 1'b1;
   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;

   typedef struct packed {
      logic              req_type;
      logic [RIDX_W-1:0] rule_index;
      logic              rule_is_dnat;
      logic [31:0]       rule_mask;
      logic              direction;
      logic [31:0]       src_addr;
      logic [31:0]       dst_addr;
      logic [15:0]       ip_checksum;
      logic [7:0]        protocol;
      logic [15:0]       l4_checksum;
      logic              l4_header_present;
      logic [1:0]        done;
      logic [ACC_W-1:0]  acc;
   } item_type;

   typedef struct packed {
      logic [31:0] new_src_addr;
      logic [31:0] new_dst_addr;
      logic [15:0] new_ip_checksum;
      logic [15:0] new_l4_checksum;
      logic        src_changed;
      logic        dst_changed;
   } rsp_type;

endpackage
`default_nettype wire

/* design/snrc_cell.sv */
`default_nettype none
module snrc_cell (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         advance,
   input  wire logic [snrc_pkg::IDX_W-1:0]   cell_index,
   input  wire logic [snrc_pkg::COUNT_W-1:0] rule_count,
   input  wire logic                         in_valid,
   input  wire snrc_pkg::item_type           in_item,
   output logic                              out_valid,
   output snrc_pkg::item_type                out_item
);
   import snrc_pkg::*;

   logic        kind_ff;
   logic [31:0] inside_ff;
   logic [31:0] mask_ff;
   logic [31:0] foreign_ff;
   logic        valid_ff;
   item_type    item_ff;
   item_type    item_in;

   logic             rule_we;
   logic             active;
   logic             pick_dst;
   logic             hit;
   logic [31:0]      addr;
   logic [31:0]      from_net;
   logic [31:0]      to_net;
   logic [31:0]      new_addr;
   logic [16:0]      old_sum;
   logic [16:0]      new_sum;
   logic [ACC_W-1:0] delta;

   assign rule_we = advance && in_valid && (in_item.req_type == REQ_LOAD) &&
                    (CMP_W'(in_item.rule_index) == CMP_W'(cell_index));
   assign active  = CMP_W'(cell_index) < CMP_W'(rule_count);

   assign pick_dst = kind_ff ^ in_item.direction;
   assign addr     = pick_dst ? in_item.dst_addr : in_item.src_addr;
   assign from_net = in_item.direction ? foreign_ff : inside_ff;
   assign to_net   = in_item.direction ? inside_ff : foreign_ff;
   assign new_addr = (addr & ~mask_ff) | to_net;
   assign hit      = (in_item.req_type == REQ_PKT) && active &&
                     ((addr & mask_ff) == from_net) && !in_item.done[pick_dst];

   // old halves minus new halves
   assign old_sum = 17'(addr[31:16]) + 17'(addr[15:0]);
   assign new_sum = 17'(new_addr[31:16]) + 17'(new_addr[15:0]);
   assign delta   = ACC_W'(old_sum) - ACC_W'(new_sum);

   always_comb begin
      item_in = in_item;
      if (hit) begin
         if (pick_dst) begin
            item_in.dst_addr = new_addr;
         end else begin
            item_in.src_addr = new_addr;
         end
         item_in.done[pick_dst] = 1'b1;
         item_in.acc            = in_item.acc + delta;
      end
   end

   always_ff @(posedge clock) begin
      if (rule_we) begin
         kind_ff    <= in_item.rule_is_dnat;
         inside_ff  <= in_item.src_addr;
         mask_ff    <= in_item.rule_mask;
         foreign_ff <= in_item.dst_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule
`default_nettype wire

/* design/snrc_cksum.sv */
`default_nettype none
module snrc_cksum (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic               in_valid,
   input  wire snrc_pkg::item_type in_item,
   output logic                    out_valid,
   output logic                    out_req_type,
   output snrc_pkg::rsp_type       out_rsp
);
   import snrc_pkg::*;

   typedef struct packed {
      logic             req_type;
      logic [31:0]      src_addr;
      logic [31:0]      dst_addr;
      logic [1:0]       done;
      logic [15:0]      ip_checksum;
      logic [15:0]      l4_checksum;
      logic [SUM_W-1:0] s_ip;
      logic [SUM_W-1:0] s_l4;
      logic             adjust;
      logic             use_l4;
   } sum_type;

   logic             valid_ff;
   sum_type          sum_ff;
   sum_type          sum_in;
   logic [SUM_W-1:0] acc_ext;

   function automatic logic [15:0] fold_adjust(input logic [SUM_W-1:0] s);
      logic [SUM_W-1:0] mag;
      logic [16:0]      v1;
      logic [15:0]      v2;
      mag = s[SUM_W-1] ? (SUM_W'(0) - s) : s;
      v1  = 17'(mag[SUM_W-1:16]) + 17'(mag[15:0]);
      v2  = v1[15:0] + 16'(v1[16]);
      return s[SUM_W-1] ? ~v2 : v2;
   endfunction

   assign acc_ext = {{(SUM_W-ACC_W){in_item.acc[ACC_W-1]}}, in_item.acc};

   always_comb begin
      sum_in.req_type    = in_item.req_type;
      sum_in.src_addr    = in_item.src_addr;
      sum_in.dst_addr    = in_item.dst_addr;
      sum_in.done        = in_item.done;
      sum_in.ip_checksum = in_item.ip_checksum;
      sum_in.l4_checksum = in_item.l4_checksum;
      sum_in.s_ip        = acc_ext + SUM_W'(in_item.ip_checksum);
      sum_in.s_l4        = acc_ext + SUM_W'(in_item.l4_checksum);
      sum_in.adjust      = in_item.done != 2'b00;
      sum_in.use_l4      = (in_item.done != 2'b00) && in_item.l4_header_present &&
                           ((in_item.protocol == PROTO_TCP) ||
                            (in_item.protocol == PROTO_UDP));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sum_ff <= sum_in;
      end
   end

   always_comb begin
      out_rsp.new_src_addr    = sum_ff.src_addr;
      out_rsp.new_dst_addr    = sum_ff.dst_addr;
      out_rsp.new_ip_checksum = sum_ff.adjust ? fold_adjust(sum_ff.s_ip) : sum_ff.ip_checksum;
      out_rsp.new_l4_checksum = sum_ff.use_l4 ? fold_adjust(sum_ff.s_l4) : sum_ff.l4_checksum;
      out_rsp.src_changed     = sum_ff.done[0];
      out_rsp.dst_changed     = sum_ff.done[1];
   end

   assign out_valid    = valid_ff;
   assign out_req_type = sum_ff.req_type;

endmodule
`default_nettype wire

/* design/static_nat_rewrite_with_checksum.sv */
// path: a packet result passes one stage per rule cell, one checksum stage and one output
// register before it shows on rsp_tvalid
// throughput: one item per cycle; a stalled output freezes the whole pipeline in place
// rule loads travel the same pipeline and write their cell on the way, producing no result
// reset: synchronous, active high; clears valid bits and rule_count, rules stay undefined
`default_nettype none
module static_nat_rewrite_with_checksum (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   // rule_index, rule_is_dnat, rule_mask, direction, src_addr, dst_addr,
   // ip_checksum, protocol, l4_checksum, l4_header_present, zero pad
   input  wire logic [151:0]                 req_tdata,
   // req_type
   input  wire logic [0:0]                   req_tuser,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   // new_src_addr, new_dst_addr, new_ip_checksum, new_l4_checksum,
   // src_changed, dst_changed, zero pad
   output logic [103:0]                      rsp_tdata,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [snrc_pkg::COUNT_W-1:0] csr_data
);
   import snrc_pkg::*;

   logic [COUNT_W-1:0] rule_count_ff;
   logic               rsp_tvalid_ff;
   logic               rsp_tvalid_in;
   rsp_type            rsp_data_ff;

   logic               advance;
   logic [MAX_RULES:0] stage_valid;
   item_type           stage_item [0:MAX_RULES];
   logic               ck_valid;
   logic               ck_req_type;
   rsp_type            ck_rsp;

   assign advance    = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = advance;
   assign csr_ready  = 1'b1;

   always_comb begin
      stage_valid[0]                  = req_tvalid;
      stage_item[0].req_type          = req_tuser[0];
      stage_item[0].rule_index        = req_tdata[5:0];
      stage_item[0].rule_is_dnat      = req_tdata[6];
      stage_item[0].rule_mask         = req_tdata[38:7];
      stage_item[0].direction         = req_tdata[39];
      stage_item[0].src_addr          = req_tdata[71:40];
      stage_item[0].dst_addr          = req_tdata[103:72];
      stage_item[0].ip_checksum       = req_tdata[119:104];
      stage_item[0].protocol          = req_tdata[127:120];
      stage_item[0].l4_checksum       = req_tdata[143:128];
      stage_item[0].l4_header_present = req_tdata[144];
      stage_item[0].done              = 2'b00;
      stage_item[0].acc               = '0;
   end

   for (genvar g = 0; g < MAX_RULES; g++) begin : g_cell
      snrc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .cell_index (IDX_W'(g)),
         .rule_count (rule_count_ff),
         .in_valid   (stage_valid[g]),
         .in_item    (stage_item[g]),
         .out_valid  (stage_valid[g+1]),
         .out_item   (stage_item[g+1])
      );
   end

   snrc_cksum u_cksum (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (stage_valid[MAX_RULES]),
      .in_item      (stage_item[MAX_RULES]),
      .out_valid    (ck_valid),
      .out_req_type (ck_req_type),
      .out_rsp      (ck_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         rule_count_ff <= csr_data;
      end
   end

   // loads drop out here
   assign rsp_tvalid_in = advance ? (ck_valid && (ck_req_type == REQ_PKT)) : rsp_tvalid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= ck_rsp;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {6'b0, rsp_data_ff.dst_changed, rsp_data_ff.src_changed,
                        rsp_data_ff.new_l4_checksum, rsp_data_ff.new_ip_checksum,
                        rsp_data_ff.new_dst_addr, rsp_data_ff.new_src_addr};

`include "static_nat_rewrite_with_checksum_assert.svh"

   `SNRC_ASSERT_NOW(a_stall_blocks_req, clock, reset, rsp_tvalid && !rsp_tready, !req_tready, "item taken while result stalled")
   `SNRC_ASSERT_NEXT(a_csr_write, clock, reset, csr_valid && csr_ready, rule_count_ff == $past(csr_data), "rule count not written")
   `SNRC_ASSERT_NEXT(a_load_no_rsp, clock, reset, advance && ck_valid && (ck_req_type == REQ_LOAD), !rsp_tvalid, "rule load produced a result")

endmodule
`default_nettype wire

/* tb/sv/static_nat_rewrite_with_checksum_checker.sv */
`timescale 1ns / 1ps
module static_nat_rewrite_with_checksum_checker
   import snrc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [151:0] req_tdata,
   input  wire logic [0:0]   req_tuser,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [103:0] rsp_tdata,
   input  wire logic         csr_valid,
   input  wire logic         csr_ready,
   input  wire logic [COUNT_W-1:0] csr_data,
   output int                errors,
   output int                outstanding
);

   logic [31:0]        inside_net [MAX_RULES];
   logic [31:0]        net_mask [MAX_RULES];
   logic [31:0]        foreign_net [MAX_RULES];
   logic               rule_kind [MAX_RULES];
   logic [COUNT_W-1:0] rules_scanned;
   rsp_type            translated_headers [$];

   initial begin
      errors = 0;
      outstanding = 0;
   end

   function automatic logic [15:0] fold_sum(logic [31:0] v);
      logic [31:0] t;
      t = {16'h0, v[31:16]} + {16'h0, v[15:0]};
      t = t + {16'h0, t[31:16]};
      return t[15:0];
   endfunction

   // one's-complement patch of a checksum by the signed address difference
   function automatic logic [15:0] patch_checksum(longint delta, logic [15:0] ck);
      longint s;
      s = delta + longint'(ck);
      if (s < 0) begin
         return ~fold_sum(32'(-s));
      end
      return fold_sum(32'(s));
   endfunction

   function automatic rsp_type translate_header(logic dir, logic [31:0] src,
                                                logic [31:0] dst, logic [15:0] ipck,
                                                logic [7:0] proto, logic [15:0] l4ck,
                                                logic present);
      rsp_type     r;
      longint      delta;
      int          n;
      logic        pick_dst;
      logic [1:0]  done;
      logic [31:0] addr;
      logic [31:0] from;
      logic [31:0] to;
      delta = 0;
      done = 2'b00;
      n = (rules_scanned > MAX_RULES) ? MAX_RULES : int'(rules_scanned);
      for (int i = 0; i < n; i++) begin
         pick_dst = rule_kind[i] ^ dir;
         addr = pick_dst ? dst : src;
         from = dir ? foreign_net[i] : inside_net[i];
         to = dir ? inside_net[i] : foreign_net[i];
         if ((addr & net_mask[i]) == from && !done[pick_dst]) begin
            delta += longint'(addr[15:0]) + longint'(addr[31:16]);
            addr = (addr & ~net_mask[i]) | to;
            delta -= longint'(addr[15:0]) + longint'(addr[31:16]);
            if (pick_dst) begin
               dst = addr;
            end else begin
               src = addr;
            end
            done[pick_dst] = 1'b1;
         end
      end
      if (done != 2'b00) begin
         ipck = patch_checksum(delta, ipck);
         if ((proto == PROTO_TCP || proto == PROTO_UDP) && present) begin
            l4ck = patch_checksum(delta, l4ck);
         end
      end
      r.new_src_addr = src;
      r.new_dst_addr = dst;
      r.new_ip_checksum = ipck;
      r.new_l4_checksum = l4ck;
      r.src_changed = done[0];
      r.dst_changed = done[1];
      return r;
   endfunction

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s expected %h got %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type got;
      rsp_type want;
      logic [5:0] idx;
      if (reset) begin
         rules_scanned = '0;
         translated_headers.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            rules_scanned = csr_data;
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser[0] == REQ_LOAD) begin
               idx = req_tdata[5:0];
               if (idx < MAX_RULES) begin
                  rule_kind[idx] = req_tdata[6];
                  net_mask[idx] = req_tdata[38:7];
                  inside_net[idx] = req_tdata[71:40];
                  foreign_net[idx] = req_tdata[103:72];
               end
            end else begin
               translated_headers.push_back(translate_header(req_tdata[39],
                  req_tdata[71:40], req_tdata[103:72], req_tdata[119:104],
                  req_tdata[127:120], req_tdata[143:128], req_tdata[144]));
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got.new_src_addr = rsp_tdata[31:0];
            got.new_dst_addr = rsp_tdata[63:32];
            got.new_ip_checksum = rsp_tdata[79:64];
            got.new_l4_checksum = rsp_tdata[95:80];
            got.src_changed = rsp_tdata[96];
            got.dst_changed = rsp_tdata[97];
            if (translated_headers.size() == 0) begin
               errors++;
               $display("%0t: no result expected, got %h", $time, rsp_tdata);
            end else begin
               want = translated_headers.pop_front();
               compare_field("new_src_addr", want.new_src_addr, got.new_src_addr);
               compare_field("new_dst_addr", want.new_dst_addr, got.new_dst_addr);
               compare_field("new_ip_checksum", 32'(want.new_ip_checksum),
                             32'(got.new_ip_checksum));
               compare_field("new_l4_checksum", 32'(want.new_l4_checksum),
                             32'(got.new_l4_checksum));
               compare_field("src_changed", 32'(want.src_changed), 32'(got.src_changed));
               compare_field("dst_changed", 32'(want.dst_changed), 32'(got.dst_changed));
            end
         end
      end
      outstanding <= translated_headers.size();
   end

endmodule

/* tb/sv/static_nat_rewrite_with_checksum_tb.sv */
`timescale 1ns / 1ps
module static_nat_rewrite_with_checksum_tb;
   import snrc_pkg::*;

   localparam int LATENCY     = MAX_RULES + 1;
   localparam int SETTLE      = LATENCY + 20;
   localparam int CYCLE_LIMIT = 300000;
   localparam int PHASE_ITEMS = 72;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [151:0]       req_tdata = '0;
   logic [0:0]         req_tuser = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [103:0]       rsp_tdata;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [COUNT_W-1:0] csr_data = '0;
   int                 errors;
   int                 outstanding;
   int                 cycle_count = 0;
   int                 stall_left = 0;
   logic               quiet = 1'b0;

   // stimulus-side copy of the table, used only to aim packets at rules
   logic [31:0]        stim_inside [MAX_RULES];
   logic [31:0]        stim_mask [MAX_RULES];
   logic [31:0]        stim_foreign [MAX_RULES];
   logic               stim_kind [MAX_RULES];

   static_nat_rewrite_with_checksum i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   static_nat_rewrite_with_checksum_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .errors      (errors),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // receiver drops rsp_tready in random bursts
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 9) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 5);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_item(logic user, logic [5:0] idx, logic dnat, logic [31:0] mask,
                            logic dir, logic [31:0] src, logic [31:0] dst,
                            logic [15:0] ipck, logic [7:0] proto, logic [15:0] l4ck,
                            logic present);
      req_tvalid <= 1'b1;
      req_tuser <= user;
      req_tdata <= {7'h0, present, l4ck, proto, ipck, dst, src, dir, mask, dnat, idx};
      do @(posedge clock); while (req_tready !== 1'b1);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic load_rule(logic [5:0] idx, logic kind, logic [31:0] mask,
                            logic [31:0] inner, logic [31:0] foreign);
      stim_kind[idx] = kind;
      stim_mask[idx] = mask;
      stim_inside[idx] = inner;
      stim_foreign[idx] = foreign;
      send_item(REQ_LOAD, idx, kind, mask, 1'($urandom), inner, foreign, 16'($urandom),
                8'($urandom), 16'($urandom), 1'($urandom));
   endtask

   task automatic send_packet(logic dir, logic [31:0] src, logic [31:0] dst,
                              logic [15:0] ipck, logic [7:0] proto, logic [15:0] l4ck,
                              logic present);
      send_item(REQ_PKT, 6'($urandom), 1'($urandom), $urandom, dir, src, dst, ipck, proto,
                l4ck, present);
   endtask

   task automatic random_rule(logic [5:0] idx);
      int          p;
      logic [31:0] mask;
      logic [31:0] inner;
      p = $urandom_range(0, 32);
      mask = (p == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - p));
      if ($urandom_range(0, 7) == 0) begin
         mask = $urandom;
      end
      inner = $urandom & mask;
      if ($urandom_range(0, 9) == 0) begin
         inner = $urandom;
      end
      load_rule(idx, 1'($urandom), mask, inner, $urandom & mask);
   endtask

   task automatic random_packet(int n);
      int          r;
      logic        dir;
      logic        pick_dst;
      logic [31:0] src;
      logic [31:0] dst;
      logic [31:0] addr;
      logic [15:0] ipck;
      logic [15:0] l4ck;
      logic [7:0]  proto;
      dir = 1'($urandom);
      src = $urandom;
      dst = $urandom;
      if ($urandom_range(0, 3) != 0) begin
         for (int k = 0; k < 2; k++) begin
            if (k == 0 || $urandom_range(0, 1) == 1) begin
               r = $urandom_range(0, n - 1);
               pick_dst = stim_kind[r] ^ dir;
               addr = ($urandom & ~stim_mask[r]) |
                      (dir ? stim_foreign[r] : stim_inside[r]);
               if (pick_dst) begin
                  dst = addr;
               end else begin
                  src = addr;
               end
            end
         end
      end
      case ($urandom_range(0, 4))
         0, 1: proto = PROTO_TCP;
         2, 3: proto = PROTO_UDP;
         default: proto = 8'($urandom);
      endcase
      ipck = 16'($urandom);
      l4ck = 16'($urandom);
      if ($urandom_range(0, 7) == 0) begin
         ipck = {16{1'($urandom)}};
      end
      if ($urandom_range(0, 7) == 0) begin
         l4ck = {16{1'($urandom)}};
      end
      send_packet(dir, src, dst, ipck, proto, l4ck, $urandom_range(0, 6) != 0);
   endtask

   task automatic wait_idle;
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic configure_rule_count(logic [COUNT_W-1:0] count);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data <= count;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      int unsigned counts [8];
      int          scan;
      counts = '{64, 1, 127, 0, 3, 65, 0, 64};
      counts[6] = $urandom_range(5, 63);
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty rule set: everything passes through
      send_packet(1'b0, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1);
      send_packet(1'b1, 32'h0, 32'hFFFF_FFFF, 16'h0, PROTO_TCP, 16'h0, 1'b0);

      load_rule(6'd0, 1'b0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
      load_rule(6'd1, 1'b1, 32'hFFFF_FF00, 32'h0A00_0000, 32'hC0A8_0100);
      load_rule(6'd2, 1'b0, 32'hFFFF_0000, 32'h0A00_0000, 32'hAC10_0000);
      load_rule(6'd3, 1'b0, 32'hFF00_0000, 32'h0A00_0000, 32'h0B00_0000);
      load_rule(6'd63, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      configure_rule_count(7'd4);

      // source rewrite to all ones, checksum sum goes negative
      send_packet(1'b0, 32'h0, 32'h0102_0304, 16'h0, PROTO_TCP, 16'h0, 1'b1);
      // incoming reversal on the destination, zero udp checksum
      send_packet(1'b1, 32'h0506_0708, 32'hFFFF_FFFF, 16'hFFFF, PROTO_UDP, 16'h0, 1'b1);
      // both addresses rewritten, l4 header missing
      send_packet(1'b0, 32'h0A00_0102, 32'h0A00_0007, 16'h1234, PROTO_UDP, 16'h5678, 1'b0);
      // source falls outside rule 2 and matches only the wider rule 3
      send_packet(1'b0, 32'h0A05_0303, 32'h0808_0808, 16'hBEEF, 8'd1, 16'hCAFE, 1'b1);
      // incoming on both addresses
      send_packet(1'b1, 32'hC0A8_0142, 32'h0B05_0303, 16'($urandom), PROTO_TCP,
                  16'($urandom), 1'b1);
      // no rule matches the first packet; the next two are rewritten
      send_packet(1'b0, 32'h0102_0304, 32'h0506_0708, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1);
      send_packet(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, PROTO_TCP, 16'hFFFF, 1'b1);
      send_packet(1'b0, 32'h0A00_FFFF, 32'h0A00_00FF, 16'h0, PROTO_TCP, 16'hFFFF, 1'b1);

      for (int i = 0; i < MAX_RULES; i++) begin
         random_rule(6'(i));
      end

      for (int p = 0; p < 8; p++) begin
         quiet = (p == 3 || p == 7);
         configure_rule_count(7'(counts[p]));
         scan = (counts[p] > MAX_RULES) ? MAX_RULES : int'(counts[p]);
         if (scan == 0) begin
            scan = MAX_RULES;
         end
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(0, 6) == 0) begin
               random_rule(6'($urandom_range(0, MAX_RULES - 1)));
            end else begin
               random_packet(scan);
            end
         end
      end

      wait_idle();
      if (errors == 0 && outstanding == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
